### design/assert_macros.svh
// Assertion macros shared by the cache RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### design/trlc_pkg.sv
// Package for the tag range line cache: sizes, kinds and queue entry type.
// Used by every module of the cache.
package trlc_pkg;
  localparam int NumLines      = 64;
  localparam int WordsPerLine  = 8;
  localparam int WordBytes     = 8;
  localparam int BacktraceCoef = 2;
  localparam int TagBits       = 32;

  localparam logic [1:0] KindPut      = 2'd0;
  localparam logic [1:0] KindFind     = 2'd1;
  localparam logic [1:0] KindFindInv  = 2'd2;
  localparam logic [1:0] KindFindWord = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first_tag;
    logic [31:0] tag;
    logic [2:0]  word_slot;
    logic [5:0]  line_select;
    logic [63:0] word_data;
    logic [3:0]  byte_count;
    logic        is_final;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  line_index;
    logic [63:0] read_data;
    logic [3:0]  read_length;
  } rsp_t;
endpackage

### design/trlc_if.sv
// Valid/ready channel carrying a payload of a given type.
// Depends on trlc_pkg for payload types.
interface trlc_req_if;
  logic valid;
  logic ready;
  trlc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trlc_rsp_if;
  logic valid;
  logic ready;
  trlc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/trlc_front.sv
// Front end: two-entry queue that accepts and buffers items.
// Depends on trlc_pkg.
module trlc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  trlc_pkg::req_t      in_data_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output trlc_pkg::req_t      q_data_o
);
  trlc_pkg::req_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i && q_valid_o) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (q_pop_i && q_valid_o) rd_q <= !rd_q;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, 1'b1, cnt_q <= 2'd2)
  `ASSERT_NEXT(a_full_after, clk_i, rst_ni, cnt_q == 2'd1 && push && !q_pop_i,
               !in_ready_o)
  `ASSERT_IMPL(a_pop_valid, clk_i, rst_ni, q_pop_i, q_valid_o)
endmodule

### design/trlc_back.sv
// Back end: sequencer over line and slot memories executing queued items.
// Depends on trlc_pkg.
module trlc_back #(
  parameter int NUM_LINES       = trlc_pkg::NumLines,
  parameter int WORDS_PER_LINE  = trlc_pkg::WordsPerLine,
  parameter int WORD_BYTES      = trlc_pkg::WordBytes,
  parameter int BACKTRACE_COEFF = trlc_pkg::BacktraceCoef,
  parameter int TAG_BITS        = trlc_pkg::TagBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  trlc_pkg::req_t q_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output trlc_pkg::rsp_t out_data_o
);
  localparam int LB = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int WB = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int NS = NUM_LINES * WORDS_PER_LINE;
  localparam int SB = (NS > 1) ? $clog2(NS) : 1;
  localparam int DB = WORD_BYTES * 8;
  localparam logic [33:0] Dist = 34'(WORDS_PER_LINE * BACKTRACE_COEFF);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLine = 3'd1;
  localparam logic [2:0] StLchk = 3'd2;
  localparam logic [2:0] StWord = 3'd3;
  localparam logic [2:0] StWchk = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [NUM_LINES-1:0] valid_q;
  logic [TAG_BITS-1:0]  first_m [NUM_LINES];
  logic [TAG_BITS-1:0]  last_m  [NUM_LINES];
  logic [TAG_BITS-1:0]  stag_m  [NS];
  logic [3:0]           slen_m  [NS];
  logic [DB-1:0]        sdat_m  [NS];

  logic [2:0]          st_q;
  trlc_pkg::req_t      req_q;
  logic [33:0]         t_q;
  logic [WB:0]         w_q;
  logic [LB-1:0]       lrd_q;
  logic [TAG_BITS-1:0] lf_q, ll_q, st_rd_q;
  logic [3:0]          sl_q;
  logic [DB-1:0]       sd_q;
  trlc_pkg::rsp_t      rsp_q;

  logic [TAG_BITS-1:0] tagm, ftag;
  logic [LB-1:0]       pline, cand;
  logic [WB-1:0]       pslot;
  logic [SB-1:0]       pidx, widx;
  logic [3:0]          plen;
  logic [DB-1:0]       pdat;
  logic [LB-1:0]       wline;

  assign tagm  = q_data_i.tag[TAG_BITS-1:0];
  assign ftag  = q_data_i.first_tag[TAG_BITS-1:0];
  assign pline = LB'(ftag % NUM_LINES);
  assign pslot = WB'(q_data_i.word_slot % WORDS_PER_LINE);
  assign pidx  = SB'(pline * WORDS_PER_LINE + pslot);
  assign plen  = (q_data_i.byte_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES)
                                                        : q_data_i.byte_count;
  assign cand  = LB'(t_q % NUM_LINES);
  assign wline = LB'(req_q.line_select);
  assign widx  = SB'(wline * WORDS_PER_LINE + w_q[WB-1:0]);
  assign pdat  = q_data_i.word_data[DB-1:0];

  assign q_pop_o     = (st_q == StIdle) && q_valid_i;
  assign out_valid_o = (st_q == StOut);
  assign out_data_o  = rsp_q;

  // Sequence one item at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      valid_q <= '0;
    end else begin
      case (st_q)
        StIdle: if (q_valid_i) begin
          if (q_data_i.kind == trlc_pkg::KindPut) begin
            if (q_data_i.is_final) valid_q[pline] <= 1'b1;
          end else if (q_data_i.kind == trlc_pkg::KindFindWord) begin
            st_q <= (32'(q_data_i.line_select) < 32'(NUM_LINES)) ? StWord : StOut;
          end else begin
            st_q <= StLine;
          end
        end
        StLine: st_q <= StLchk;
        StLchk: begin
          if (valid_q[lrd_q] && lf_q <= req_q.tag[TAG_BITS-1:0] &&
              req_q.tag[TAG_BITS-1:0] <= ll_q) begin
            if (req_q.kind == trlc_pkg::KindFindInv) valid_q[lrd_q] <= 1'b0;
            st_q <= StOut;
          end else if (t_q >= 34'(req_q.tag[TAG_BITS-1:0])) begin
            st_q <= StOut;
          end else begin
            st_q <= StLine;
          end
        end
        StWord: st_q <= StWchk;
        StWchk: begin
          if (st_rd_q == req_q.tag[TAG_BITS-1:0] ||
              w_q == (WB+1)'(WORDS_PER_LINE - 1)) st_q <= StOut;
          else st_q <= StWord;
        end
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  // Datapath registers and memories
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (q_valid_i) begin
        req_q <= q_data_i;
        rsp_q <= '0;
        t_q   <= (34'(tagm) > Dist) ? 34'(tagm) - Dist : 34'd0;
        w_q   <= '0;
        if (q_data_i.kind == trlc_pkg::KindPut) begin
          stag_m[pidx] <= tagm;
          slen_m[pidx] <= plen;
          // Write only the low plen bytes, keep the rest
          for (int b = 0; b < WORD_BYTES; b++) begin
            if (b < int'(plen)) sdat_m[pidx][b*8 +: 8] <= pdat[b*8 +: 8];
          end
          if (q_data_i.is_final) begin
            first_m[pline] <= ftag;
            last_m[pline]  <= tagm;
          end
        end
      end
      StLine: begin
        lrd_q <= cand;
        lf_q  <= first_m[cand];
        ll_q  <= last_m[cand];
      end
      StLchk: begin
        if (valid_q[lrd_q] && lf_q <= req_q.tag[TAG_BITS-1:0] &&
            req_q.tag[TAG_BITS-1:0] <= ll_q) begin
          rsp_q.found      <= 1'b1;
          rsp_q.line_index <= 6'(lrd_q);
        end
        t_q <= t_q + 34'd1;
      end
      StWord: begin
        st_rd_q <= stag_m[widx];
        sl_q    <= slen_m[widx];
        sd_q    <= sdat_m[widx];
      end
      StWchk: begin
        if (st_rd_q == req_q.tag[TAG_BITS-1:0]) begin
          rsp_q.found       <= 1'b1;
          rsp_q.read_data   <= 64'(sd_q);
          rsp_q.read_length <= sl_q;
        end
        w_q <= w_q + 1'b1;
      end
      default: ;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, !q_pop_o)
  `ASSERT_NEXT(a_out_stay, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_pop_o, st_q == StIdle)
endmodule

### design/tag_range_line_cache.sv
// Tag range line cache: find line probes candidate lines from tag-W*C up to tag,
// find word scans the slots of one line; one memory read per probe sets the pace.
// Results are held in an output register; a two-entry queue keeps input open.
// Asynchronous active-low reset clears line valid bits and control; the word
// and tag stores are not cleared.
module tag_range_line_cache #(
  parameter int NUM_LINES       = trlc_pkg::NumLines,
  parameter int WORDS_PER_LINE  = trlc_pkg::WordsPerLine,
  parameter int WORD_BYTES      = trlc_pkg::WordBytes,
  parameter int BACKTRACE_COEFF = trlc_pkg::BacktraceCoef,
  parameter int TAG_BITS        = trlc_pkg::TagBits
) (
  input logic       clk_i,
  input logic       rst_ni,
  trlc_req_if.sink   in_if,
  trlc_rsp_if.source out_if
);
  logic           q_valid, q_pop;
  trlc_pkg::req_t q_data;

  // Accept and buffer items
  trlc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  // Execute items
  trlc_back #(
    .NUM_LINES(NUM_LINES), .WORDS_PER_LINE(WORDS_PER_LINE),
    .WORD_BYTES(WORD_BYTES), .BACKTRACE_COEFF(BACKTRACE_COEFF), .TAG_BITS(TAG_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule
